// ----- src/tbmrp_pkg.sv -----
// Shared types and constants for the time-bounded least-risk route core.
// Used by the core top level; no dependencies.
package tbmrp_pkg;

   // Request codes on req_type
   localparam logic [1:0] REQ_LOAD_TIME = 2'd0;
   localparam logic [1:0] REQ_LOAD_RISK = 2'd1;
   localparam logic [1:0] REQ_START     = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_NUM_STATIONS = 1'b0;
   localparam logic CSR_TIME_BUDGET  = 1'b1;

   // Width of an accumulated risk in the table
   localparam int RISK_W = 17;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_RD,
      ST_SEED_WR,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_SRC_CHK,
      ST_PREV_RD,
      ST_PREV_WR,
      ST_FIN_RD,
      ST_FIN_OUT
   } seq_state_type;

endpackage

// ----- src/tbmrp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbmrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word; the read word is registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- src/time_bounded_min_risk_path_core.sv -----
// Top level of the time-bounded least-risk route core.
// Depends on tbmrp_pkg and tbmrp_ram.
//
// Usage. A request beat is taken at a rising edge with start high and busy
// low. req_type selects: load one time matrix entry, load one risk matrix
// entry (both done in that cycle, busy stays low), or start the solve.
// A start fills the table over budget rows 0..time_budget and stations
// 0..num_stations-1, then puts one result beat on rsp_* with rsp_valid high
// for one cycle: least risk and its time for the last station, or no_path.
// A start holds busy high for the whole solve, and the result beat comes in
// the cycle after the last busy cycle. Each predecessor edge is read through
// the shared matrix read address and the table read port.
// Loads are taken one beat per cycle while busy is low.
// The user must write the csr port (num_stations, time_budget) only while
// idle; the core does not enforce it. Synchronous reset returns the
// sequencer to idle and the registers to num_stations 1, time_budget 0;
// matrices and table hold undefined data until written. The receiver cannot
// stall: the result beat is lost if not taken in its cycle.
module time_bounded_min_risk_path_core
   import tbmrp_pkg::*;
#(
   parameter int MAX_STATIONS = 128,
   parameter int MAX_BUDGET   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [6:0]  req_from_station,
   input  logic [6:0]  req_to_station,
   input  logic [7:0]  req_entry_value,
   output logic        rsp_valid,
   output logic [15:0] rsp_min_risk,
   output logic [7:0]  rsp_total_time,
   output logic        rsp_no_path,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [7:0]  csr_write_data
);

   localparam int SW  = $clog2(MAX_STATIONS);
   localparam int BW  = $clog2(MAX_BUDGET);
   localparam int TW  = (BW > 8) ? BW : 8;
   localparam int EW  = 1 + RISK_W + TW;
   localparam int MAW = 2 * SW;
   localparam int TAW = BW + SW;

   seq_state_type state_ff, state_in;

   logic [7:0]        num_ff, tb_cfg_ff;
   logic [BW-1:0]     b_ff, tb_ff;
   logic [SW-1:0]     j_ff, k_ff, nl_ff;
   logic [7:0]        e_ff, er_ff;
   logic              zero_ff, have_ff;
   logic [RISK_W-1:0] br_ff;
   logic [TW-1:0]     bt_ff;

   logic              mat_we_t, mat_we_r;
   logic [MAW-1:0]    mat_wa, mat_ra;
   logic [7:0]        tmat_rd, rmat_rd;
   logic              tab_we;
   logic [TAW-1:0]    tab_wa, tab_ra;
   logic [EW-1:0]     tab_wd, tab_rd;

   logic              src_ok, cand_take, prev_take, j_last, k_last, accept;
   logic [RISK_W-1:0] src_r, cand_r, tab_r;
   logic [TW-1:0]     src_t, cand_t, tab_t, b_ext, e_ext;
   logic              tab_reach, in_range;
   logic [SW-1:0]     nl_sat;
   logic [BW-1:0]     tb_sat;

   assign accept    = start && !busy;
   assign in_range  = (int'(req_from_station) < MAX_STATIONS) &&
                      (int'(req_to_station) < MAX_STATIONS);
   assign tab_reach = tab_rd[EW-1];
   assign tab_r     = tab_rd[TW +: RISK_W];
   assign tab_t     = tab_rd[TW-1:0];
   assign b_ext     = TW'(b_ff);
   assign e_ext     = TW'(e_ff);
   assign j_last    = (j_ff == nl_ff);
   assign k_last    = (k_ff == nl_ff);

   // Clamp the station count and budget taken at start
   always_comb begin
      if (num_ff == 8'd0) begin
         nl_sat = '0;
      end else if (int'(num_ff) > MAX_STATIONS) begin
         nl_sat = SW'(MAX_STATIONS - 1);
      end else begin
         nl_sat = SW'(num_ff - 8'd1);
      end
      if (int'(tb_cfg_ff) > MAX_BUDGET - 1) begin
         tb_sat = BW'(MAX_BUDGET - 1);
      end else begin
         tb_sat = BW'(tb_cfg_ff);
      end
   end

   // Source offer of a predecessor: seed for zero-time edges, else earlier row
   always_comb begin
      if (zero_ff) begin
         src_ok = (TW'(tmat_rd) <= b_ext);
         src_r  = RISK_W'(rmat_rd);
         src_t  = TW'(tmat_rd);
      end else begin
         src_ok = tab_reach;
         src_r  = tab_r;
         src_t  = tab_t;
      end
      cand_r    = src_r + RISK_W'(er_ff);
      cand_t    = src_t + e_ext;
      cand_take = src_ok && (!have_ff || (cand_r < br_ff));
      prev_take = tab_reach && (!have_ff || (tab_r < br_ff) ||
                  ((tab_r == br_ff) && (tab_t < bt_ff)));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_START)) state_in = ST_SEED_RD;
         end
         ST_SEED_RD: state_in = ST_SEED_WR;
         ST_SEED_WR: begin
            if (!j_last) state_in = ST_SEED_RD;
            else if (tb_ff == '0) state_in = ST_FIN_RD;
            else state_in = ST_EDGE_RD;
         end
         ST_EDGE_RD: state_in = ST_EDGE_CHK;
         ST_EDGE_CHK: begin
            if (TW'(tmat_rd) <= b_ext) state_in = ST_SRC_CHK;
            else if (k_last) state_in = ST_PREV_RD;
            else state_in = ST_EDGE_RD;
         end
         ST_SRC_CHK: state_in = k_last ? ST_PREV_RD : ST_EDGE_RD;
         ST_PREV_RD: state_in = ST_PREV_WR;
         ST_PREV_WR: begin
            if (j_last && (b_ff == tb_ff)) state_in = ST_FIN_RD;
            else state_in = ST_EDGE_RD;
         end
         ST_FIN_RD:  state_in = ST_FIN_OUT;
         ST_FIN_OUT: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Memory addresses and table writes per state
   always_comb begin
      busy     = (state_ff != ST_IDLE);
      mat_we_t = accept && (req_type == REQ_LOAD_TIME) && in_range;
      mat_we_r = accept && (req_type == REQ_LOAD_RISK) && in_range;
      mat_wa   = {SW'(req_from_station), SW'(req_to_station)};
      mat_ra   = {k_ff, j_ff};
      tab_we   = 1'b0;
      tab_wa   = {b_ff, j_ff};
      tab_wd   = '0;
      tab_ra   = {BW'(b_ext - TW'(tmat_rd)), k_ff};
      case (state_ff)
         ST_SEED_RD: mat_ra = {SW'(0), j_ff};
         ST_SEED_WR: begin
            tab_we = 1'b1;
            tab_wa = {BW'(0), j_ff};
            tab_wd = {(tmat_rd == 8'd0), RISK_W'(rmat_rd), TW'(tmat_rd)};
         end
         ST_EDGE_CHK: mat_ra = {SW'(0), k_ff};
         ST_PREV_RD:  tab_ra = {BW'(b_ff - BW'(1)), j_ff};
         ST_PREV_WR: begin
            tab_we = 1'b1;
            if (prev_take) tab_wd = {1'b1, tab_r, tab_t};
            else if (have_ff) tab_wd = {1'b1, br_ff, bt_ff};
            else tab_wd = '0;
         end
         ST_FIN_RD: tab_ra = {tb_ff, nl_ff};
         default: ;
      endcase
   end

   // Sequencer state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         num_ff    <= 8'd1;
         tb_cfg_ff <= 8'd0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rsp_valid <= (state_ff == ST_FIN_OUT);
         if (csr_write_enable) begin
            if (csr_index == CSR_NUM_STATIONS) num_ff <= csr_write_data;
            else tb_cfg_ff <= csr_write_data;
         end
      end
   end

   // Loop counters, running best and result beat
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            nl_ff <= nl_sat;
            tb_ff <= tb_sat;
            j_ff  <= '0;
         end
         ST_SEED_WR: begin
            j_ff    <= j_last ? '0 : j_ff + SW'(1);
            b_ff    <= BW'(1);
            k_ff    <= '0;
            have_ff <= 1'b0;
         end
         ST_EDGE_CHK: begin
            e_ff    <= tmat_rd;
            er_ff   <= rmat_rd;
            zero_ff <= (tmat_rd == 8'd0);
            if ((TW'(tmat_rd) > b_ext) && !k_last) k_ff <= k_ff + SW'(1);
         end
         ST_SRC_CHK: begin
            if (cand_take) begin
               have_ff <= 1'b1;
               br_ff   <= cand_r;
               bt_ff   <= cand_t;
            end
            if (!k_last) k_ff <= k_ff + SW'(1);
         end
         ST_PREV_WR: begin
            k_ff    <= '0;
            have_ff <= 1'b0;
            if (j_last) begin
               j_ff <= '0;
               b_ff <= b_ff + BW'(1);
            end else begin
               j_ff <= j_ff + SW'(1);
            end
         end
         ST_FIN_OUT: begin
            if (tab_reach && (tab_t <= TW'(tb_ff))) begin
               rsp_min_risk   <= (|tab_r[RISK_W-1:16]) ? 16'hFFFF : tab_r[15:0];
               rsp_total_time <= tab_t[7:0];
               rsp_no_path    <= 1'b0;
            end else begin
               rsp_min_risk   <= 16'd0;
               rsp_total_time <= 8'd0;
               rsp_no_path    <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   tbmrp_ram #(.WIDTH(8), .DEPTH(1 << MAW)) u_time_mat (
      .clock(clock), .wr_en(mat_we_t), .wr_addr(mat_wa),
      .wr_data(req_entry_value), .rd_addr(mat_ra), .rd_data(tmat_rd)
   );

   tbmrp_ram #(.WIDTH(8), .DEPTH(1 << MAW)) u_risk_mat (
      .clock(clock), .wr_en(mat_we_r), .wr_addr(mat_wa),
      .wr_data(req_entry_value), .rd_addr(mat_ra), .rd_data(rmat_rd)
   );

   tbmrp_ram #(.WIDTH(EW), .DEPTH(1 << TAW)) u_table (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_wa),
      .wr_data(tab_wd), .rd_addr(tab_ra), .rd_data(tab_rd)
   );

`ifndef SYNTHESIS
   // A result beat lands only while idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");

   // One result beat per solve
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat repeated");

   // No-path result carries zero payload
   a_no_path_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_no_path) |-> (rsp_min_risk == 16'd0 &&
      rsp_total_time == 8'd0)) else $error("no-path beat with payload");

   // A load beat never starts the sequencer
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type != REQ_START) |=> !busy)
      else $error("load beat left core busy");
`endif

endmodule

// ----- bench/tb_time_bounded_min_risk_path_core.sv -----
// Self-checking bench for time_bounded_min_risk_path_core: loads travel-time and risk
// matrices, runs solves and checks every result beat against a behavioural route predictor.
// Depends on tbmrp_pkg and the core RTL.
module tb_time_bounded_min_risk_path_core
   import tbmrp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam int NST = 128;
   localparam int UNREACH = 1 << 29;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = REQ_LOAD_TIME;
   logic [6:0]  req_from_station = '0;
   logic [6:0]  req_to_station = '0;
   logic [7:0]  req_entry_value = '0;
   logic        rsp_valid;
   logic [15:0] rsp_min_risk;
   logic [7:0]  rsp_total_time;
   logic        rsp_no_path;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_NUM_STATIONS;
   logic [7:0]  csr_write_data = '0;

   time_bounded_min_risk_path_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expected route results and running mismatch count
   typedef struct {
      logic [15:0] risk;
      logic [7:0]  ttime;
      logic        no_path;
   } route_type;
   localparam route_type NO_RES = '{16'd0, 8'd0, 1'b0};
   route_type route_q[$];
   int        errors = 0;

   // Model state: matrices, registers and the budget-by-station table
   byte unsigned time_m[NST*NST];
   byte unsigned risk_m[NST*NST];
   int           stations_reg = 1;
   int           budget_reg = 0;
   bit           reach_t[256][NST];
   int           risk_t[256][NST];
   int           time_t[256][NST];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic bit same_route(input route_type a, input route_type b);
      return (a.risk === b.risk) && (a.ttime === b.ttime) && (a.no_path === b.no_path);
   endfunction

   function automatic route_type solve_route();
      int        n, tb, e, sr, st, br, bt, s0;
      bit        have, ok;
      route_type res;
      n = (stations_reg == 0) ? 1 : (stations_reg > NST ? NST : stations_reg);
      tb = budget_reg;
      for (int j = 0; j < n; j++) begin
         reach_t[0][j] = (time_m[j] == 0);
         risk_t[0][j]  = risk_m[j];
         time_t[0][j]  = time_m[j];
      end
      for (int b = 1; b <= tb; b++) begin
         for (int j = 0; j < n; j++) begin
            have = 0;
            br = UNREACH;
            bt = UNREACH;
            for (int k = 0; k < n; k++) begin
               e = time_m[k*NST+j];
               if (e > b) continue;
               if (e == 0) begin
                  s0 = time_m[k];
                  ok = (s0 <= b);
                  sr = risk_m[k];
                  st = s0;
               end else begin
                  ok = reach_t[b-e][k];
                  sr = risk_t[b-e][k];
                  st = time_t[b-e][k];
               end
               if (!ok) continue;
               sr += risk_m[k*NST+j];
               if (!have || sr < br) begin
                  have = 1;
                  br = sr;
                  bt = st + e;
               end
            end
            // keep the previous-budget entry on lower risk, or equal risk and less time
            if (reach_t[b-1][j] && (!have || risk_t[b-1][j] < br ||
                (risk_t[b-1][j] == br && time_t[b-1][j] < bt))) begin
               have = 1;
               br = risk_t[b-1][j];
               bt = time_t[b-1][j];
            end
            reach_t[b][j] = have;
            risk_t[b][j]  = have ? br : 0;
            time_t[b][j]  = have ? (bt & 16'hFFFF) : 0;
         end
      end
      if (reach_t[tb][n-1] && time_t[tb][n-1] <= tb) begin
         res.risk    = (risk_t[tb][n-1] > 65535) ? 16'hFFFF : risk_t[tb][n-1][15:0];
         res.ttime   = time_t[tb][n-1][7:0];
         res.no_path = 1'b0;
      end else begin
         res = NO_RES;
         res.no_path = 1'b1;
      end
      return res;
   endfunction

   // Drive one request beat, hold it until taken, then update the model
   task automatic send_req(input logic [1:0] kind, input logic [6:0] fr, input logic [6:0] to,
                           input logic [7:0] val, input bit typed, input route_type typed_res);
      route_type pred;
      start <= 1'b1;
      req_type <= kind;
      req_from_station <= fr;
      req_to_station <= to;
      req_entry_value <= val;
      do @(posedge clock); while (busy);
      if (kind == REQ_LOAD_TIME) time_m[int'(fr)*NST+int'(to)] = val;
      else if (kind == REQ_LOAD_RISK) risk_m[int'(fr)*NST+int'(to)] = val;
      else if (kind == REQ_START) begin
         pred = solve_route();
         if (typed && !same_route(pred, typed_res))
            report_mismatch("model disagrees with typed expectation");
         route_q.push_back(typed ? typed_res : pred);
      end
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Write a register only once the core is idle and all results are in
   task automatic csr_write(input logic idx, input logic [7:0] val);
      start <= 1'b0;
      @(posedge clock);
      while (route_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_NUM_STATIONS) stations_reg = int'(val);
      else budget_reg = int'(val);
   endtask

   // Load every entry of both matrices over the n-by-n block in use
   task automatic fill_block(input int n, input int tmax, input bit gaps);
      for (int f = 0; f < n; f++)
         for (int t = 0; t < n; t++) begin
            send_req(REQ_LOAD_TIME, 7'(f), 7'(t),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, tmax)),
                     1'b0, NO_RES);
            send_req(REQ_LOAD_RISK, 7'(f), 7'(t), 8'($urandom_range(0, 255)), 1'b0, NO_RES);
            if (gaps) idle_gap(pick_gap());
         end
   endtask

   // Result checker: each strobe must match the oldest expectation
   always @(posedge clock) begin
      route_type want;
      if (!reset && rsp_valid) begin
         if (route_q.size() == 0) report_mismatch("result beat with nothing expected");
         else begin
            want = route_q.pop_front();
            if (rsp_min_risk !== want.risk)
               report_mismatch($sformatf("min_risk %0d want %0d", rsp_min_risk, want.risk));
            if (rsp_total_time !== want.ttime)
               report_mismatch($sformatf("total_time %0d want %0d", rsp_total_time, want.ttime));
            if (rsp_no_path !== want.no_path)
               report_mismatch($sformatf("no_path %0b want %0b", rsp_no_path, want.no_path));
         end
      end
   end

   // Directed stimulus table
   typedef struct {
      bit          is_csr;
      logic        idx;
      logic [1:0]  kind;
      logic [6:0]  fr;
      logic [6:0]  to;
      logic [7:0]  val;
      bit          typed;
      route_type   res;
   } step_type;

   step_type steps[] = '{
      '{0, 0, REQ_LOAD_TIME, 0, 0, 8'd0,   0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_RISK, 0, 0, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   1, '{16'd255, 8'd0, 1'b0}},
      '{0, 0, REQ_LOAD_TIME, 0, 0, 8'd1,   0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   1, '{16'd0, 8'd0, 1'b1}},
      '{0, 0, REQ_NONE,      127, 127, 8'd255, 0, '{0, 0, 0}},
      '{1, CSR_TIME_BUDGET, REQ_NONE, 0, 0, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   1, '{16'd0, 8'd0, 1'b1}},
      '{1, CSR_NUM_STATIONS, REQ_NONE, 0, 0, 8'd2, 0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_TIME, 0, 0, 8'd0,   0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_TIME, 0, 1, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_TIME, 1, 0, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_TIME, 1, 1, 8'd0,   0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_RISK, 0, 1, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_RISK, 1, 0, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_RISK, 1, 1, 8'd255, 0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   0, '{0, 0, 0}},
      '{1, CSR_TIME_BUDGET, REQ_NONE, 0, 0, 8'd0, 0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   1, '{16'd0, 8'd0, 1'b1}},
      '{0, 0, REQ_LOAD_TIME, 0, 1, 8'd0,   0, '{0, 0, 0}},
      '{0, 0, REQ_LOAD_RISK, 0, 1, 8'd0,   0, '{0, 0, 0}},
      '{0, 0, REQ_START,     0, 0, 8'd0,   1, '{16'd0, 8'd0, 1'b0}}
   };

   initial begin
      int n, bud, items, r;
      bit dense;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (steps[i]) begin
         if (steps[i].is_csr) csr_write(steps[i].idx, steps[i].val);
         else begin
            send_req(steps[i].kind, steps[i].fr, steps[i].to, steps[i].val,
                     steps[i].typed, steps[i].res);
            idle_gap(pick_gap());
         end
      end

      // station count of zero runs as one station
      csr_write(CSR_NUM_STATIONS, 8'd0);
      send_req(REQ_START, 7'd0, 7'd0, 8'd0, 1'b0, NO_RES);

      // random phases: choose a size, load the block, then mix loads, starts and no-op requests
      items = 0;
      while (items < 750) begin
         r = $urandom_range(0, 9);
         n = (r < 8) ? $urandom_range(1, 6) : $urandom_range(7, 10);
         bud = (r == 9) ? $urandom_range(0, 30) : $urandom_range(0, 12);
         if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 3);
            bud = $urandom_range(200, 255);
         end
         csr_write(CSR_NUM_STATIONS, 8'(n));
         csr_write(CSR_TIME_BUDGET, 8'(bud));
         dense = ($urandom_range(0, 3) == 0);
         fill_block(n, (bud < 4) ? 2 : bud / 2, !dense);
         items += 2 * n * n;
         for (int i = 0; i < 25; i++) begin
            r = $urandom_range(0, 99);
            if (r < 25)
               send_req(REQ_START, 7'($urandom), 7'($urandom), 8'($urandom), 1'b0, NO_RES);
            else if (r < 30)
               send_req(REQ_NONE, 7'($urandom), 7'($urandom), 8'($urandom), 1'b0, NO_RES);
            else
               send_req((r < 65) ? REQ_LOAD_TIME : REQ_LOAD_RISK,
                        7'($urandom_range(0, n - 1)), 7'($urandom_range(0, n - 1)),
                        (r < 65) ? 8'($urandom_range(0, bud + 1)) : 8'($urandom),
                        1'b0, NO_RES);
            items++;
            if (!dense) idle_gap(pick_gap());
         end
      end

      // drain
      start <= 1'b0;
      while (route_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #200ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ----- filelist.f -----
src/tbmrp_pkg.sv
src/tbmrp_ram.sv
src/time_bounded_min_risk_path_core.sv
bench/tb_time_bounded_min_risk_path_core.sv
